@@ hw/rtl/eba_pkg.sv @@
// eba_pkg: operation codes, flag bit positions and shared structs for the
// accumulator ALU. No dependencies.
`default_nettype none

package eba_pkg;

    // operation codes of the input beat
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_ADC      = 4'd1,
        OP_SUB      = 4'd2,
        OP_SBC      = 4'd3,
        OP_AND      = 4'd4,
        OP_XOR      = 4'd5,
        OP_OR       = 4'd6,
        OP_CP       = 4'd7,
        OP_INC      = 4'd8,
        OP_DEC      = 4'd9,
        OP_CPL      = 4'd10,
        OP_RLCA     = 4'd11,
        OP_RRA      = 4'd12,
        OP_LOAD     = 4'd13,
        OP_EXCHANGE = 4'd14
    } op_t;

    // flag bit positions
    localparam int unsigned FLAG_C  = 0;
    localparam int unsigned FLAG_N  = 1;
    localparam int unsigned FLAG_PV = 2;
    localparam int unsigned FLAG_H  = 4;
    localparam int unsigned FLAG_Z  = 6;
    localparam int unsigned FLAG_S  = 7;

    // special operand values for inc/dec overflow and half carry
    localparam logic [7:0] BYTE_MAX_POS = 8'h7f;
    localparam logic [7:0] BYTE_MIN_NEG = 8'h80;
    localparam logic [3:0] NIBBLE_ONES  = 4'hf;

    // architectural state seen by the alu
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] flags;
        logic [7:0] alt_acc;
        logic [7:0] alt_flags;
    } alu_state_t;

    // alu outcome for one beat
    typedef struct packed {
        logic [7:0] result;
        logic [7:0] acc;
        logic [7:0] flags;
        logic       swap;
    } alu_out_t;

endpackage : eba_pkg

`default_nettype wire

@@ hw/rtl/eight_bit_accumulator_alu.sv @@
// eight_bit_accumulator_alu: top level with input register, accumulator
// and flag state, alternate pair and result register. Uses eba_pkg, eba_alu.
//
// Usage:
//   Input channel s_valid/s_ready carries one beat: s_operation (4 bits)
//   and s_operand (8 bits). Result channel m_valid/m_ready returns one beat
//   per input beat: m_result_byte, m_accumulator_out, m_flags_out.
//   Path: a beat accepted into the input register passes the alu and lands
//   in the result register, which drives m_valid and the result outputs.
//   Throughput: one beat per cycle while m_ready is high. The accumulator
//   and flags are written at the same edge as the result register, so a
//   following beat in the input register already sees the new state.
//   Reset (aresetn low, synchronous): accumulator, flags and the alternate
//   pair clear to zero and both registers empty.
//   Stall: when m_ready is low with a result waiting, the result stays,
//   the input register holds one more beat and then s_ready drops; nothing
//   is lost or repeated.
`default_nettype none

module eight_bit_accumulator_alu (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [3:0] s_operation,
    input  wire logic [7:0] s_operand,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_result_byte,
    output logic [7:0]      m_accumulator_out,
    output logic [7:0]      m_flags_out
);
    import eba_pkg::*;

    logic       in_valid_reg;
    logic [3:0] in_op_reg;
    logic [7:0] in_operand_reg;
    logic       out_valid_reg;
    logic [7:0] out_result_reg;
    logic [7:0] out_acc_reg;
    logic [7:0] out_flags_reg;
    alu_state_t state_reg;
    alu_state_t state_next;
    alu_out_t   outcome;
    logic       advance;
    logic       commit;

    // pipeline control
    assign advance = !out_valid_reg || m_ready;
    assign commit  = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg      <= s_operation;
            in_operand_reg <= s_operand;
        end
    end

    eba_alu u_alu (
        .operation (in_op_reg),
        .operand   (in_operand_reg),
        .state     (state_reg),
        .outcome   (outcome)
    );

    // next architectural state
    always_comb begin
        state_next       = state_reg;
        state_next.acc   = outcome.acc;
        state_next.flags = outcome.flags;
        if (outcome.swap) begin
            state_next.alt_acc   = state_reg.acc;
            state_next.alt_flags = state_reg.flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (commit) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_result_reg <= outcome.result;
            out_acc_reg    <= outcome.acc;
            out_flags_reg  <= outcome.flags;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_byte     = out_result_reg;
    assign m_accumulator_out = out_acc_reg;
    assign m_flags_out       = out_flags_reg;

    // exchange moves the old pair into the alternate slot
    a_exchange_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && in_op_reg == OP_EXCHANGE) |=>
            (state_reg.alt_acc == $past(state_reg.acc)) &&
            (state_reg.alt_flags == $past(state_reg.flags)))
        else $error("exchange did not save the old accumulator pair");

    // compare, inc and dec leave the accumulator alone
    a_acc_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (in_op_reg == OP_CP || in_op_reg == OP_INC ||
                    in_op_reg == OP_DEC)) |=> $stable(state_reg.acc))
        else $error("accumulator changed on compare/inc/dec");

    // result beat mirrors the state it committed
    a_out_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (out_acc_reg == state_reg.acc) &&
                   (out_flags_reg == state_reg.flags))
        else $error("result beat differs from committed state");

    // unused flag bits stay clear
    a_flag_gaps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.flags[5] == 1'b0) && (state_reg.flags[3] == 1'b0))
        else $error("reserved flag bit set");

endmodule : eight_bit_accumulator_alu

`default_nettype wire

@@ hw/rtl/eba_alu.sv @@
// eba_alu: combinational datapath for one operation, adder/subtractor,
// logic ops, rotates and flag generation. Depends on eba_pkg.
`default_nettype none

module eba_alu (
    input  wire logic [3:0]          operation,
    input  wire logic [7:0]          operand,
    input  wire eba_pkg::alu_state_t state,
    output eba_pkg::alu_out_t        outcome
);
    import eba_pkg::*;

    op_t        op;
    logic [7:0] a;
    logic [7:0] n;
    logic [7:0] f;
    logic       cin;
    logic       use_carry;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] dif9;
    logic [4:0] dif_lo;
    logic [7:0] add_r;
    logic [7:0] sub_r;
    logic [7:0] add_f;
    logic [7:0] sub_f;
    logic [7:0] log_r;
    logic [7:0] inc_r;
    logic [7:0] dec_r;
    logic [7:0] tmp_r;

    assign op        = op_t'(operation);
    assign a         = state.acc;
    assign n         = operand;
    assign f         = state.flags;
    assign use_carry = (op == OP_ADC) || (op == OP_SBC);
    assign cin       = use_carry & f[FLAG_C];

    // adder with half carry and overflow
    assign sum9   = {1'b0, a} + {1'b0, n} + {8'd0, cin};
    assign sum_lo = {1'b0, a[3:0]} + {1'b0, n[3:0]} + {4'd0, cin};
    assign add_r  = sum9[7:0];
    always_comb begin
        add_f          = '0;
        add_f[FLAG_S]  = add_r[7];
        add_f[FLAG_Z]  = (add_r == 8'd0);
        add_f[FLAG_H]  = sum_lo[4];
        add_f[FLAG_PV] = ~(a[7] ^ n[7]) & (a[7] ^ add_r[7]);
        add_f[FLAG_C]  = sum9[8];
    end

    // subtractor with half borrow and overflow
    assign dif9   = {1'b0, a} - {1'b0, n} - {8'd0, cin};
    assign dif_lo = {1'b0, a[3:0]} - {1'b0, n[3:0]} - {4'd0, cin};
    assign sub_r  = dif9[7:0];
    always_comb begin
        sub_f          = '0;
        sub_f[FLAG_S]  = sub_r[7];
        sub_f[FLAG_Z]  = (sub_r == 8'd0);
        sub_f[FLAG_H]  = dif_lo[4];
        sub_f[FLAG_PV] = (a[7] ^ n[7]) & (a[7] ^ sub_r[7]);
        sub_f[FLAG_N]  = 1'b1;
        sub_f[FLAG_C]  = dif9[8];
    end

    assign inc_r = n + 8'd1;
    assign dec_r = n - 8'd1;

    // logic ops share one flag pattern, but H is set only for AND
    always_comb begin
        unique case (op)
            OP_AND:  log_r = a & n;
            OP_XOR:  log_r = a ^ n;
            default: log_r = a | n;
        endcase
    end

    // operation select
    always_comb begin
        outcome.swap   = 1'b0;
        outcome.acc    = a;
        outcome.flags  = f;
        outcome.result = a;
        tmp_r          = a;
        unique case (op)
            OP_ADD, OP_ADC: begin
                outcome.acc    = add_r;
                outcome.flags  = add_f;
                outcome.result = add_r;
            end
            OP_SUB, OP_SBC: begin
                outcome.acc    = sub_r;
                outcome.flags  = sub_f;
                outcome.result = sub_r;
            end
            OP_CP: begin
                outcome.flags  = sub_f;
            end
            OP_AND, OP_XOR, OP_OR: begin
                outcome.acc            = log_r;
                outcome.result         = log_r;
                outcome.flags          = '0;
                outcome.flags[FLAG_S]  = log_r[7];
                outcome.flags[FLAG_Z]  = (log_r == 8'd0);
                outcome.flags[FLAG_PV] = ~^log_r;
                outcome.flags[FLAG_H]  = (op == OP_AND);
            end
            OP_INC: begin
                outcome.result         = inc_r;
                outcome.flags          = '0;
                outcome.flags[FLAG_C]  = f[FLAG_C];
                outcome.flags[FLAG_S]  = inc_r[7];
                outcome.flags[FLAG_Z]  = (inc_r == 8'd0);
                outcome.flags[FLAG_H]  = (n[3:0] == NIBBLE_ONES);
                outcome.flags[FLAG_PV] = (n == BYTE_MAX_POS);
            end
            OP_DEC: begin
                outcome.result         = dec_r;
                outcome.flags          = '0;
                outcome.flags[FLAG_C]  = f[FLAG_C];
                outcome.flags[FLAG_N]  = 1'b1;
                outcome.flags[FLAG_S]  = dec_r[7];
                outcome.flags[FLAG_Z]  = (dec_r == 8'd0);
                outcome.flags[FLAG_H]  = (n[3:0] == 4'd0);
                outcome.flags[FLAG_PV] = (n == BYTE_MIN_NEG);
            end
            OP_CPL: begin
                tmp_r                 = ~a;
                outcome.acc           = tmp_r;
                outcome.result        = tmp_r;
                outcome.flags[FLAG_H] = 1'b1;
                outcome.flags[FLAG_N] = 1'b1;
            end
            OP_RLCA: begin
                tmp_r                 = {a[6:0], a[7]};
                outcome.acc           = tmp_r;
                outcome.result        = tmp_r;
                outcome.flags[FLAG_H] = 1'b0;
                outcome.flags[FLAG_N] = 1'b0;
                outcome.flags[FLAG_C] = a[7];
            end
            OP_RRA: begin
                tmp_r                 = {f[FLAG_C], a[7:1]};
                outcome.acc           = tmp_r;
                outcome.result        = tmp_r;
                outcome.flags[FLAG_H] = 1'b0;
                outcome.flags[FLAG_N] = 1'b0;
                outcome.flags[FLAG_C] = a[0];
            end
            OP_LOAD: begin
                outcome.acc    = n;
                outcome.result = n;
            end
            OP_EXCHANGE: begin
                outcome.swap   = 1'b1;
                outcome.acc    = state.alt_acc;
                outcome.flags  = state.alt_flags;
                outcome.result = state.alt_acc;
            end
            default: begin
                // unused code: nothing changes
                outcome.swap = 1'b0;
            end
        endcase
    end

endmodule : eba_alu

`default_nettype wire
